### src/scl_pkg.sv
package scl_pkg;

  localparam int MaxLineDef = 4096;
  // token bundles parked between lexer and output stage; power of two
  localparam int QueueDepth = 4;
  localparam int OffW       = 12;
  localparam int LenW       = 13;

  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChPipe  = 8'h7C;

  typedef enum logic [2:0] {
    KIND_WORD    = 3'd0,
    KIND_PIPE    = 3'd1,
    KIND_IN      = 3'd2,
    KIND_OUT     = 3'd3,
    KIND_HEREDOC = 3'd4,
    KIND_APPEND  = 3'd5,
    KIND_END     = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    LEX_IDLE = 2'd0,
    LEX_WORD = 2'd1,
    LEX_LT   = 2'd2,
    LEX_GT   = 2'd3
  } lex_mode_e;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_e;

  typedef struct packed {
    kind_e            kind;
    logic [OffW-1:0]  start;
    logic [LenW-1:0]  len;
    logic             ovf;
    logic             last;
  } rec_t;

  // all records caused by one input transaction
  typedef struct packed {
    logic two;
    rec_t r0;
    rec_t r1;
  } bundle_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic rec_t make_rec(input kind_e k, input logic [OffW-1:0] s,
                                    input logic [LenW-1:0] l, input logic o);
    rec_t r;
    r.kind  = k;
    r.start = s;
    r.len   = l;
    r.ovf   = o;
    r.last  = 1'b1;
    return r;
  endfunction

endpackage

### src/scl_front.sv
module scl_front #(
  parameter int MAX_LINE = scl_pkg::MaxLineDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       char_i,
  input  logic             line_end_i,
  output logic             push_o,
  output scl_pkg::bundle_t bundle_o
);
  import scl_pkg::*;

  localparam int PosW = $clog2(MAX_LINE + 1);
  localparam int BegW = $clog2(MAX_LINE);
  localparam logic [PosW-1:0] MaxPos  = PosW'(MAX_LINE);
  localparam logic [BegW-1:0] LastBeg = BegW'(MAX_LINE - 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic [BegW-1:0] beg_q, beg_d;
  lex_mode_e       mode_q, mode_d;
  quote_e          quote_q, quote_d;
  logic            ovf_q, ovf_d;

  logic            at_max, ovf_now, op_hit, word_brk;
  logic [BegW-1:0] here;
  logic [PosW-1:0] beg_ext, word_len;
  logic            have_a, have_b;
  rec_t            rec_a, rec_b, word_rec;
  quote_e          quote_tog;
  // start_token effects
  lex_mode_e       st_mode;
  logic            st_pipe, st_load;
  quote_e          st_quote;

  always_comb begin
    at_max   = (pos_q >= MaxPos);
    ovf_now  = ovf_q | (!line_end_i & at_max);
    here     = at_max ? LastBeg : pos_q[BegW-1:0];
    beg_ext  = PosW'(beg_q);
    word_len = (pos_q > beg_ext) ? (pos_q - beg_ext) : '0;
    word_rec = make_rec(KIND_WORD, OffW'(beg_q), LenW'(word_len), ovf_now);
    op_hit   = (mode_q == LEX_LT) ? (char_i == ChLt) : (char_i == ChGt);
    word_brk = (quote_q == Q_NONE) && ((char_i == ChSpace) || (char_i == ChTab) ||
               (char_i == ChPipe) || (char_i == ChLt) || (char_i == ChGt));

    quote_tog = quote_q;
    if (quote_q == Q_NONE) begin
      if (char_i == ChDq) quote_tog = Q_DOUBLE;
      else if (char_i == ChSq) quote_tog = Q_SINGLE;
    end else if ((quote_q == Q_SINGLE && char_i == ChSq) ||
                 (quote_q == Q_DOUBLE && char_i == ChDq)) begin
      quote_tog = Q_NONE;
    end

    st_mode  = LEX_IDLE;
    st_pipe  = 1'b0;
    st_load  = 1'b0;
    st_quote = quote_q;
    priority if (is_blank(char_i)) begin
      st_mode = LEX_IDLE;
    end else if (char_i == ChPipe) begin
      st_pipe = 1'b1;
    end else if (char_i == ChLt) begin
      st_mode = LEX_LT;
      st_load = 1'b1;
    end else if (char_i == ChGt) begin
      st_mode = LEX_GT;
      st_load = 1'b1;
    end else begin
      st_mode  = LEX_WORD;
      st_load  = 1'b1;
      st_quote = (char_i == ChDq) ? Q_DOUBLE : (char_i == ChSq) ? Q_SINGLE : Q_NONE;
    end

    have_a  = 1'b0;
    have_b  = 1'b0;
    rec_a   = word_rec;
    rec_b   = make_rec(KIND_PIPE, OffW'(here), LenW'(1), ovf_now);
    pos_d   = (pos_q < MaxPos) ? pos_q + PosW'(1) : pos_q;
    beg_d   = beg_q;
    mode_d  = mode_q;
    quote_d = quote_q;
    ovf_d   = ovf_now;

    if (line_end_i) begin
      // flush whatever is open, then the end token; state back to reset
      unique case (mode_q)
        LEX_WORD: have_a = 1'b1;
        LEX_LT: begin
          have_a = 1'b1;
          rec_a  = make_rec(KIND_IN, OffW'(beg_q), LenW'(1), ovf_now);
        end
        LEX_GT: begin
          have_a = 1'b1;
          rec_a  = make_rec(KIND_OUT, OffW'(beg_q), LenW'(1), ovf_now);
        end
        default: have_a = 1'b0;
      endcase
      have_b  = 1'b1;
      rec_b   = make_rec(KIND_END, OffW'(at_max ? LastBeg : pos_q[BegW-1:0]),
                         '0, ovf_now);
      pos_d   = '0;
      beg_d   = '0;
      mode_d  = LEX_IDLE;
      quote_d = Q_NONE;
      ovf_d   = 1'b0;
    end else begin
      unique case (mode_q)
        LEX_WORD: begin
          if (word_brk) begin
            have_a  = 1'b1;
            have_b  = st_pipe;
            mode_d  = st_mode;
            quote_d = Q_NONE;
            if (st_load) beg_d = here;
          end else begin
            quote_d = quote_tog;
          end
        end
        LEX_LT, LEX_GT: begin
          have_a = 1'b1;
          if (op_hit) begin
            rec_a  = make_rec((mode_q == LEX_LT) ? KIND_HEREDOC : KIND_APPEND,
                              OffW'(beg_q), LenW'(2), ovf_now);
            mode_d = LEX_IDLE;
          end else begin
            rec_a   = make_rec((mode_q == LEX_LT) ? KIND_IN : KIND_OUT,
                               OffW'(beg_q), LenW'(1), ovf_now);
            have_b  = st_pipe;
            mode_d  = st_mode;
            quote_d = st_quote;
            if (st_load) beg_d = here;
          end
        end
        default: begin
          have_b  = st_pipe;
          mode_d  = st_mode;
          quote_d = st_quote;
          if (st_load) beg_d = here;
        end
      endcase
    end

    push_o = fire_i & (have_a | have_b);
    if (have_a) begin
      bundle_o.two     = have_b;
      bundle_o.r0      = rec_a;
      bundle_o.r0.last = !have_b;
      bundle_o.r1      = rec_b;
    end else begin
      bundle_o.two = 1'b0;
      bundle_o.r0  = rec_b;
      bundle_o.r1  = rec_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      beg_q   <= '0;
      mode_q  <= LEX_IDLE;
      quote_q <= Q_NONE;
      ovf_q   <= 1'b0;
    end else if (fire_i) begin
      pos_q   <= pos_d;
      beg_q   <= beg_d;
      mode_q  <= mode_d;
      quote_q <= quote_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

### src/scl_queue.sv
module scl_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  scl_pkg::bundle_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output scl_pkg::bundle_t pop_data_o,
  output logic             empty_o
);
  import scl_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  bundle_t         mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PtrW'(1);
      if (pop_i) rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

### src/scl_back.sv
module scl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  scl_pkg::bundle_t bundle_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output scl_pkg::rec_t    out_rec_o
);
  import scl_pkg::*;

  logic out_valid_q, out_valid_d;
  rec_t out_rec_q, out_rec_d;
  logic pend_q, pend_d;     // second record of a bundle still to send
  rec_t pend_rec_q, pend_rec_d;
  logic can_load;

  always_comb begin
    can_load    = !out_valid_q || out_ready_i;
    out_valid_d = out_valid_q;
    out_rec_d   = out_rec_q;
    pend_d      = pend_q;
    pend_rec_d  = pend_rec_q;
    pop_o       = 1'b0;
    if (can_load) begin
      priority if (pend_q) begin
        out_valid_d = 1'b1;
        out_rec_d   = pend_rec_q;
        pend_d      = 1'b0;
      end else if (!empty_i) begin
        pop_o       = 1'b1;
        out_valid_d = 1'b1;
        out_rec_d   = bundle_i.r0;
        pend_d      = bundle_i.two;
        pend_rec_d  = bundle_i.r1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_rec_q;

  always_ff @(posedge clk_i) begin
    out_rec_q  <= out_rec_d;
    pend_rec_q <= pend_rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

endmodule

### src/shell_command_lexer.sv
// Byte-serial shell command line tokenizer. Each slave transaction carries one
// byte of the line (tlast low) or the line-end marker (tlast high, data
// ignored). Blanks (space, tab through CR) are skipped between tokens; a word
// runs until an unquoted space, tab, '|', '<' or '>', and single/double quotes
// keep separators inside the word. A lone '<' or '>' is held one byte to tell
// it from "<<" / ">>". Each master transaction is one token record: kind in
// tuser, start offset, length and the line-overflow flag in tdata, and tlast
// set on the final record caused by an input transaction. Line end flushes
// the open token and adds an end token, then the next byte starts a new line
// at offset 0. Start offsets saturate at MAX_LINE - 1, and a byte past the
// first MAX_LINE sets the overflow flag for the rest of the line; start offset
// and length go out truncated to 12 and 13 bits. Throughput: one input byte per
// cycle. The lexer front end registers its state on each accepted byte and
// drops that byte's 0..2 records into a 4-deep queue; the output stage drains
// one record per cycle while the receiver is ready, so a byte that yields two
// records (word then pipe, operator then pipe, or a token flushed at line end)
// needs a second output transfer, absorbed by the queue. Input ready drops only
// when the queue is full. Records go through the queue and the output register.
module shell_command_lexer #(
  parameter int MAX_LINE = scl_pkg::MaxLineDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_byte
  input  logic        s_axis_tlast,  // line_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [11:0] start_offset, [24:12] token_length,
                                     // [25] overflow, [31:26] zero
  output logic [2:0]  m_axis_tuser,  // [2:0] token_kind
  output logic        m_axis_tlast   // last_result
);
  import scl_pkg::*;

  logic    in_fire, push, full, pop, empty;
  bundle_t push_bundle, pop_bundle;
  rec_t    out_rec;

  assign s_axis_tready = !full;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  scl_front #(
    .MAX_LINE(MAX_LINE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .char_i     (s_axis_tdata),
    .line_end_i (s_axis_tlast),
    .push_o     (push),
    .bundle_o   (push_bundle)
  );

  scl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_bundle),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_bundle),
    .empty_o     (empty)
  );

  scl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .bundle_i    (pop_bundle),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rec_o   (out_rec)
  );

  assign m_axis_tdata = {6'b0, out_rec.ovf, out_rec.len, out_rec.start};
  assign m_axis_tuser = out_rec.kind;
  assign m_axis_tlast = out_rec.last;

endmodule

### test/shell_command_lexer_tb.sv
module shell_command_lexer_tb;
  import scl_pkg::*;

  // line limit as the block is built by default
  localparam int unsigned LineMax    = MaxLineDef;
  localparam int          CycleLimit = 200000;
  localparam int          PhaseItems = 112;
  localparam int          HoldCycles = 300;
  localparam int          MaxReports = 30;

  typedef enum logic [1:0] {
    PACE_FULL,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH
  } pace_e;

  typedef struct packed {
    logic       eol;
    logic [7:0] ch;
  } line_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  line_item_t  char_q[$];
  line_item_t  cur_item;
  rec_t        token_q[$];
  pace_e       pace = PACE_FULL;
  int          err_cnt = 0;
  int          queued_cnt = 0;
  int          cycle_cnt = 0;
  int          hold_left = 0;
  logic        hold_req = 1'b0;

  // lexer state as seen by the predictor
  int unsigned line_pos = 0;
  lex_mode_e   lex_st = LEX_IDLE;
  quote_e      quote_st = Q_NONE;
  int unsigned tok_begin = 0;
  logic        ovf_seen = 1'b0;

  shell_command_lexer #(
    .MAX_LINE(LineMax)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic blank_byte(logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic int unsigned clamped_pos();
    return (line_pos >= LineMax) ? LineMax - 1 : line_pos;
  endfunction

  function automatic void push_token(kind_e k, int unsigned s, int unsigned l);
    rec_t r;
    r.kind  = k;
    r.start = s[OffW-1:0];
    r.len   = l[LenW-1:0];
    r.ovf   = ovf_seen;
    r.last  = 1'b0;
    token_q.push_back(r);
  endfunction

  function automatic void flip_quote(logic [7:0] c);
    if (quote_st == Q_NONE) begin
      if (c == ChDq) quote_st = Q_DOUBLE;
      else if (c == ChSq) quote_st = Q_SINGLE;
    end else if ((quote_st == Q_SINGLE && c == ChSq) || (quote_st == Q_DOUBLE && c == ChDq)) begin
      quote_st = Q_NONE;
    end
  endfunction

  function automatic void close_word();
    int unsigned e;
    e = (line_pos > LineMax) ? LineMax : line_pos;
    push_token(KIND_WORD, tok_begin, (e > tok_begin) ? e - tok_begin : 0);
    lex_st   = LEX_IDLE;
    quote_st = Q_NONE;
  endfunction

  function automatic void open_token(logic [7:0] c, int unsigned here);
    lex_st = LEX_IDLE;
    if (blank_byte(c)) return;
    if (c == ChPipe) begin
      push_token(KIND_PIPE, here, 1);
    end else if (c == ChLt) begin
      lex_st    = LEX_LT;
      tok_begin = here;
    end else if (c == ChGt) begin
      lex_st    = LEX_GT;
      tok_begin = here;
    end else begin
      lex_st    = LEX_WORD;
      tok_begin = here;
      quote_st  = Q_NONE;
      flip_quote(c);
    end
  endfunction

  // one accepted input transaction -> zero, one or two expected token records
  function automatic void lex_item(line_item_t it);
    int          n_prior;
    int unsigned here;
    logic [7:0]  c;
    n_prior = token_q.size();
    c       = it.ch;
    if (it.eol) begin
      case (lex_st)
        LEX_WORD: close_word();
        LEX_LT:   push_token(KIND_IN, tok_begin, 1);
        LEX_GT:   push_token(KIND_OUT, tok_begin, 1);
        default: ;
      endcase
      push_token(KIND_END, clamped_pos(), 0);
      line_pos  = 0;
      lex_st    = LEX_IDLE;
      quote_st  = Q_NONE;
      tok_begin = 0;
      ovf_seen  = 1'b0;
    end else begin
      if (line_pos >= LineMax) ovf_seen = 1'b1;
      here = clamped_pos();
      case (lex_st)
        LEX_WORD: begin
          if (quote_st == Q_NONE &&
              (c == ChSpace || c == ChTab || c == ChPipe || c == ChLt || c == ChGt)) begin
            close_word();
            open_token(c, here);
          end else begin
            flip_quote(c);
          end
        end
        LEX_LT, LEX_GT: begin
          if (c == ((lex_st == LEX_LT) ? ChLt : ChGt)) begin
            push_token((lex_st == LEX_LT) ? KIND_HEREDOC : KIND_APPEND, tok_begin, 2);
            lex_st = LEX_IDLE;
          end else begin
            push_token((lex_st == LEX_LT) ? KIND_IN : KIND_OUT, tok_begin, 1);
            open_token(c, here);
          end
        end
        default: open_token(c, here);
      endcase
      if (line_pos < LineMax) line_pos++;
    end
    if (token_q.size() > n_prior) token_q[token_q.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- pacing

  function automatic logic send_gap();
    case (pace)
      PACE_SEND_GAPS: return $urandom_range(0, 99) < 83;
      PACE_BOTH:      return $urandom_range(0, 99) < 25;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic logic recv_stall();
    case (pace)
      PACE_RECV_STALLS: return $urandom_range(0, 99) < 83;
      PACE_BOTH:        return $urandom_range(0, 99) < 25;
      default:          return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) lex_item(cur_item);
      if (s_axis_tvalid && !s_axis_tready) begin
        // keep offering the same transaction
      end else if (char_q.size() != 0 && !send_gap()) begin
        cur_item      = char_q.pop_front();
        s_axis_tvalid <= 1'b1;
        // byte is don't-care on line end, so randomize it
        s_axis_tdata  <= cur_item.eol ? 8'($urandom_range(0, 255)) : cur_item.ch;
        s_axis_tlast  <= cur_item.eol;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, started by a pulse on hold_req
  always @(posedge clk_i) begin
    if (hold_req) hold_left <= HoldCycles;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && (hold_left == 0) && !recv_stall();
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_cnt++;
      if (err_cnt <= MaxReports) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : token_mon
    rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (token_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReports)
          $error("unexpected token record: kind %0d data %h", m_axis_tuser, m_axis_tdata);
      end else begin
        want = token_q.pop_front();
        check_field("token_kind", want.kind, m_axis_tuser);
        check_field("start_offset", want.start, m_axis_tdata[11:0]);
        check_field("token_length", want.len, m_axis_tdata[24:12]);
        check_field("overflow", want.ovf, m_axis_tdata[25]);
        check_field("last_result", want.last, m_axis_tlast);
        check_field("tdata_pad", 0, m_axis_tdata[31:26]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_char(logic [7:0] c);
    char_q.push_back('{eol: 1'b0, ch: c});
    queued_cnt++;
  endtask

  task automatic queue_line_end();
    char_q.push_back('{eol: 1'b1, ch: 8'h00});
    queued_cnt++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endtask

  task automatic queue_blank();
    if ($urandom_range(0, 2) == 0) queue_char(ChSpace);
    else queue_char(ChTab + 8'($urandom_range(0, 4)));
  endtask

  // mostly well-formed command lines; some raw noise
  task automatic queue_random_line();
    int ntok;
    int pick;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 12)) queue_char(8'($urandom_range(0, 255)));
    end else begin
      ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 5);
      repeat (ntok) begin
        repeat ($urandom_range(0, 2)) queue_blank();
        case ($urandom_range(0, 9))
          5: queue_char(ChPipe);
          6: queue_char(ChLt);
          7: queue_char(ChGt);
          8: queue_text("<<");
          9: queue_text(">>");
          default: begin
            repeat ($urandom_range(1, 6)) begin
              pick = $urandom_range(0, 19);
              if (pick < 13) queue_char(8'h61 + 8'($urandom_range(0, 25)));
              else if (pick < 15) queue_char(ChSq);
              else if (pick < 17) queue_char(ChDq);
              else if (pick == 17) queue_char((pick & 1) ? ChPipe : ChSpace);
              else if (pick == 18) queue_char($urandom_range(0, 1) ? ChLt : ChGt);
              else queue_char(8'($urandom_range(0, 255)));
            end
          end
        endcase
      end
      repeat ($urandom_range(0, 1)) queue_blank();
    end
    queue_line_end();
  endtask

  task automatic wait_drained();
    while (char_q.size() != 0 || s_axis_tvalid || token_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: all blanks, quoted separator, word then pipe
    queue_char(ChSpace);
    for (int c = ChTab; c <= ChCr; c++) queue_char(8'(c));
    queue_text("'a b'|");
    queue_line_end();
    // heredoc, redirect then pending '>', append, zero byte as word,
    // operator then pipe, pending '>' flushed at line end
    queue_text("<<<>>");
    queue_char(8'h00);
    queue_text("<|>");
    queue_line_end();
    // unclosed quote at line end, then an empty line
    queue_char(ChDq);
    queue_char(8'hFF);
    queue_line_end();
    queue_line_end();
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      pace       = pace_e'(ph);
      queued_cnt = 0;
      while (queued_cnt < PhaseItems) queue_random_line();
      if (pace == PACE_FULL) begin
        // back-pressure: sender keeps going while the receiver holds off
        hold_req = 1'b1;
        @(negedge clk_i);
        hold_req = 1'b0;
      end
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
src/scl_pkg.sv
src/scl_front.sv
src/scl_queue.sv
src/scl_back.sv
src/shell_command_lexer.sv
test/shell_command_lexer_tb.sv
